// File: hdl/htf_pkg.sv
// Package for the HTTP header field tokenizer: payload structs, parser phase
// codes, result kind codes and the delimiter characters.
// No dependencies.
package htf_pkg;

  // Field widths.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned LimitW = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned PhaseW = 4;

  // Result kind codes.
  localparam logic [KindW-1:0] KIND_SKIP  = 3'd0;
  localparam logic [KindW-1:0] KIND_KEY   = 3'd1;
  localparam logic [KindW-1:0] KIND_VALUE = 3'd2;
  localparam logic [KindW-1:0] KIND_PAIR  = 3'd3;
  localparam logic [KindW-1:0] KIND_ENDCR = 3'd4;
  localparam logic [KindW-1:0] KIND_HDONE = 3'd5;
  localparam logic [KindW-1:0] KIND_ERROR = 3'd6;
  localparam logic [KindW-1:0] KIND_AFTER = 3'd7;

  // Parser phase codes.
  localparam logic [PhaseW-1:0] PH_START = 4'd0;
  localparam logic [PhaseW-1:0] PH_KEY   = 4'd1;
  localparam logic [PhaseW-1:0] PH_COLON = 4'd2;
  localparam logic [PhaseW-1:0] PH_SPACE = 4'd3;
  localparam logic [PhaseW-1:0] PH_VALUE = 4'd4;
  localparam logic [PhaseW-1:0] PH_CR    = 4'd5;
  localparam logic [PhaseW-1:0] PH_LF    = 4'd6;
  localparam logic [PhaseW-1:0] PH_ENDCR = 4'd7;
  localparam logic [PhaseW-1:0] PH_DONE  = 4'd8;
  localparam logic [PhaseW-1:0] PH_ERROR = 4'd9;

  // Delimiter characters.
  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CH_COLON = 8'h3A;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;

  localparam logic [LimitW-1:0] VALUE_LIMIT_RESET = 10'd255;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             restart;
  } htf_in_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ByteW-1:0]  echo_byte;
    logic [CountW-1:0] value_length;
  } htf_out_t;

endpackage

// File: hdl/http_header_field_tokenizer_core.sv
// Results are registered in the output register, or in the skid register when stalled.
// Throughput: one byte per cycle; a stalled result is held in an output
// register and one more is caught in a skid register, so input stalls only
// when both are full. Reset (rst_ni low, asynchronous) puts the parser in the
// start phase, clears the value count, sets value_limit to 255 and empties
// the output and skid registers.
// Top level of the HTTP header field tokenizer; depends on htf_pkg.
module http_header_field_tokenizer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [htf_pkg::LimitW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  htf_pkg::htf_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output htf_pkg::htf_out_t             out_data_o
);
  import htf_pkg::*;

  // Config register; the user must write it only while idle (not enforced).
  logic [LimitW-1:0] value_limit_q;

  // Parser state carried from one byte to the next.
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;

  // Output register and the skid register behind it.
  logic     out_valid_q, skid_valid_q;
  htf_out_t out_q, skid_q;
  htf_out_t result;

  logic in_xfer;
  logic out_free;

  // The input stalls only when the skid register holds a result, which can
  // happen only while the output register is also full and stalled.
  assign in_stall_o  = skid_valid_q;
  assign in_xfer     = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next-state and result logic for one byte. A restart takes effect before
  // the byte is looked at, so the byte is parsed from the start phase.
  always_comb begin
    logic [PhaseW-1:0] cur_phase;
    logic [CountW-1:0] cur_count;
    logic [ByteW-1:0]  b;
    logic              is_eol;

    b         = in_data_i.data_byte;
    cur_phase = in_data_i.restart ? PH_START : phase_q;
    cur_count = in_data_i.restart ? '0 : count_q;
    is_eol    = (b == CH_CR) || (b == CH_LF);

    phase_d             = cur_phase;
    count_d             = cur_count;
    result.kind         = KIND_ERROR;
    result.echo_byte    = b;
    result.value_length = '0;

    case (cur_phase)
      PH_START: begin
        if (is_eol) begin
          result.kind = KIND_SKIP;
        end else begin
          result.kind = KIND_KEY;
          phase_d     = PH_KEY;
        end
      end
      PH_KEY: begin
        if (b == CH_COLON) begin
          result.kind = KIND_SKIP;
          phase_d     = PH_COLON;
        end else if (is_eol) begin
          phase_d = PH_ERROR;
        end else begin
          result.kind = KIND_KEY;
        end
      end
      PH_COLON: begin
        if (b == CH_SPACE) begin
          result.kind = KIND_SKIP;
          phase_d     = PH_SPACE;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_SPACE: begin
        // Whatever follows the space opens the value, a CR included.
        result.kind = KIND_VALUE;
        count_d     = CountW'(1);
        phase_d     = PH_VALUE;
      end
      PH_VALUE: begin
        if (b == CH_CR) begin
          result.kind = KIND_SKIP;
          phase_d     = PH_CR;
        end else if (cur_count > {1'b0, value_limit_q}) begin
          phase_d = PH_ERROR;
        end else begin
          result.kind = KIND_VALUE;
          count_d     = cur_count + CountW'(1);
        end
      end
      PH_CR: begin
        if (b == CH_LF) begin
          result.kind         = KIND_PAIR;
          result.value_length = cur_count;
          phase_d             = PH_LF;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_LF: begin
        if (b == CH_CR) begin
          result.kind = KIND_ENDCR;
          phase_d     = PH_ENDCR;
        end else begin
          result.kind = KIND_KEY;
          phase_d     = PH_KEY;
        end
      end
      PH_ENDCR: begin
        if (b == CH_LF) begin
          result.kind = KIND_HDONE;
          phase_d     = PH_DONE;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_DONE: begin
        result.kind = KIND_AFTER;
      end
      default: begin
        // The error phase and the unused codes stay in error.
        phase_d = PH_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_limit_q <= VALUE_LIMIT_RESET;
      phase_q       <= PH_START;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        value_limit_q <= cfg_data_i;
      end
      if (in_xfer) begin
        phase_q <= phase_d;
        count_q <= count_d;
      end
      if (out_free) begin
        // The skid register drains first; a new byte is never taken while
        // the skid register is full.
        out_valid_q  <= skid_valid_q || in_xfer;
        skid_valid_q <= 1'b0;
      end else if (in_xfer) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_xfer) begin
        out_q <= result;
      end
    end else if (in_xfer) begin
      skid_q <= result;
    end
  end

endmodule

// File: hdl/htf_checker.sv
// Port-level checker for the HTTP header field tokenizer, bound to the top.
// Depends on htf_pkg and http_header_field_tokenizer_core.
module htf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input htf_pkg::htf_out_t          out_data_o
);
  import htf_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // The input can only stall while a result is waiting at the output.
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // A length is reported only on a completed pair.
  a_len_only_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind != KIND_PAIR) |-> (out_data_o.value_length == '0))
    else $error("value length on a result that is not pair done");

  // A completed value holds at least one byte and never more than 1024.
  a_pair_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_PAIR) |->
      (out_data_o.value_length != '0) && (out_data_o.value_length <= CountW'(1024)))
    else $error("pair done with impossible value length");

endmodule

bind http_header_field_tokenizer_core htf_checker u_htf_checker (.*);
